/* sv/fpr_pkg.sv */
`default_nettype none
package fpr_pkg;

    localparam int unsigned TW_WORDS = 12;
    localparam int unsigned MASK_W   = 16;
    localparam int unsigned DIV_W    = 64;
    localparam int unsigned PIX_W    = 49;
    localparam int unsigned FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        OP_XFORM = 2'd0,
        OP_BOX   = 2'd1,
        OP_POINT = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_FOCAL_X  = 3'd0,
        REG_FOCAL_Y  = 3'd1,
        REG_CENTER_X = 3'd2,
        REG_CENTER_Y = 3'd3,
        REG_ACTIVE   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [3:0]         slot;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
        logic signed [31:0] value_c;
        logic [15:0]        value_d;
        logic [15:0]        point_intensity;
    } t_in;

    typedef struct packed {
        logic [15:0]        inside_mask;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [15:0]        out_intensity;
        logic               behind_sensor;
        logic               depth_invalid;
    } t_out;

    typedef struct packed {
        logic [31:0] focal_x;
        logic [31:0] focal_y;
        logic [31:0] center_x;
        logic [31:0] center_y;
        logic [4:0]  active_boxes;
    } t_cfg;

    typedef struct packed {
        t_in  item;
        logic behind;
        logic zinv;
        logic neg_u;
        logic neg_v;
    } t_pl;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] w;
        logic [15:0]        h;
    } t_box;

endpackage
`default_nettype wire

/* sv/fpr_div.sv */
`default_nettype none
module fpr_div (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_dvd,
    input  wire logic [31:0] i_dvs,
    output logic [63:0]      o_quo
);

    localparam int unsigned N = fpr_pkg::DIV_W;

    logic [31:0] w_rem [0:N];
    logic [63:0] w_dvd [0:N];
    logic [63:0] w_quo [0:N];
    logic [31:0] w_dvs [0:N];

    logic [31:0] r_rem [0:N-1];
    logic [63:0] r_dvd [0:N-1];
    logic [63:0] r_quo [0:N-1];
    logic [31:0] r_dvs [0:N-1];

    assign w_rem[0] = '0;
    assign w_dvd[0] = i_dvd;
    assign w_quo[0] = '0;
    assign w_dvs[0] = i_dvs;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [32:0] t;
        logic        ge;
        logic [32:0] diff;
        assign t    = {w_rem[k], w_dvd[k][63]};
        assign diff = t - {1'b0, w_dvs[k]};
        assign ge   = (t >= {1'b0, w_dvs[k]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[31:0] : t[31:0];
                r_dvd[k] <= {w_dvd[k][62:0], 1'b0};
                r_quo[k] <= {w_quo[k][62:0], ge};
                r_dvs[k] <= w_dvs[k];
            end
        end
        assign w_rem[k+1] = r_rem[k];
        assign w_dvd[k+1] = r_dvd[k];
        assign w_quo[k+1] = r_quo[k];
        assign w_dvs[k+1] = r_dvs[k];
    end

    assign o_quo = w_quo[N];

endmodule
`default_nettype wire

/* sv/fpr_fifo.sv */
`default_nettype none
module fpr_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire fpr_pkg::t_out i_data,
    output logic               o_full,
    output logic               o_empty,
    input  wire logic          i_rd,
    output fpr_pkg::t_out      o_data
);

    localparam int unsigned D  = fpr_pkg::FIFO_DEPTH;
    localparam int unsigned AW = $clog2(D);

    fpr_pkg::t_out r_mem [0:D-1];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          w_wr, w_rd;

    assign o_full  = (r_cnt == (AW+1)'(D));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_wr) - (AW+1)'(w_rd);
        end
    end

endmodule
`default_nettype wire

/* sv/fpr_front.sv */
`default_nettype none
module fpr_front #(
    parameter int unsigned MAX_BOXES = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire fpr_pkg::t_in  i_item,
    input  wire fpr_pkg::t_cfg i_cfg,
    output logic               o_valid,
    output fpr_pkg::t_out      o_res
);

    localparam int unsigned NB  = (MAX_BOXES < fpr_pkg::MASK_W) ? MAX_BOXES : fpr_pkg::MASK_W;
    localparam int unsigned IW  = (NB > 1) ? $clog2(NB) : 1;
    localparam int unsigned LAT = fpr_pkg::DIV_W;
    localparam int unsigned PIX_W_L = fpr_pkg::PIX_W;

    logic signed [31:0] r_tw [0:fpr_pkg::TW_WORDS-1];
    fpr_pkg::t_box      r_box [0:NB-1];

    fpr_pkg::t_pl       w_pl0;
    logic               r1_v;
    fpr_pkg::t_pl       r1_pl;
    logic signed [63:0] r1_prod [0:8];

    logic               r2_v;
    fpr_pkg::t_pl       r2_pl;
    logic signed [31:0] r2_cam [0:2];

    fpr_pkg::t_pl       w_pl3;
    logic               r3_v;
    fpr_pkg::t_pl       r3_pl;
    logic [63:0]        r3_dvd_u, r3_dvd_v;
    logic [31:0]        r3_mz;

    logic               r_dl_v  [0:LAT-1];
    fpr_pkg::t_pl       r_dl_pl [0:LAT-1];
    logic [63:0]        w_qu, w_qv;

    logic               r4_v;
    fpr_pkg::t_pl       r4_pl;
    logic signed [PIX_W_L-1:0] r4_u, r4_v_pix;

    function automatic logic signed [PIX_W_L-1:0] f_pix(
        input logic [63:0] q, input logic neg, input logic [31:0] ctr);
        logic [63:0]        qc;
        logic signed [63:0] sq, s, t;
        begin
            qc = (q > 64'h4000_0000_0000_0000) ? 64'h4000_0000_0000_0000 : q;
            sq = neg ? -$signed(qc) : $signed(qc);
            s  = sq + $signed({32'd0, ctr});
            t  = s[63] ? (s + 64'sd65535) : s;
            f_pix = PIX_W_L'(t >>> 16);
        end
    endfunction

    function automatic logic [31:0] f_abs(input logic signed [31:0] x);
        f_abs = x[31] ? (32'd0 - x) : x;
    endfunction

    assign w_pl0.item   = i_item;
    assign w_pl0.behind = i_item.value_a[31];
    assign w_pl0.zinv   = 1'b0;
    assign w_pl0.neg_u  = 1'b0;
    assign w_pl0.neg_v  = 1'b0;

    // transform words apply at accept; products of this beat use the old words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fpr_pkg::TW_WORDS; i++) r_tw[i] <= '0;
        end else if (i_valid && i_item.opcode == fpr_pkg::OP_XFORM
                     && i_item.slot < 4'(fpr_pkg::TW_WORDS)) begin
            r_tw[i_item.slot] <= i_item.value_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            for (int i = 0; i < LAT; i++) r_dl_v[i] <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r_dl_v[0] <= r3_v;
            for (int i = 1; i < LAT; i++) r_dl_v[i] <= r_dl_v[i-1];
            r4_v <= r_dl_v[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pl <= w_pl0;
            for (int r = 0; r < 3; r++) begin
                r1_prod[3*r+0] <= r_tw[3*r+0] * i_item.value_a;
                r1_prod[3*r+1] <= r_tw[3*r+1] * i_item.value_b;
                r1_prod[3*r+2] <= r_tw[3*r+2] * i_item.value_c;
            end
        end
    end

    logic signed [65:0] w_sum [0:2];
    logic signed [65:0] w_cam [0:2];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_sum[r] = 66'(r1_prod[3*r]) + 66'(r1_prod[3*r+1]) + 66'(r1_prod[3*r+2]);
            w_cam[r] = (w_sum[r] >>> 16) + 66'(r_tw[9+r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_pl <= r1_pl;
            for (int r = 0; r < 3; r++) begin
                if (w_cam[r] > 66'sd2147483647)       r2_cam[r] <= 32'sh7FFF_FFFF;
                else if (w_cam[r] < -66'sd2147483648) r2_cam[r] <= 32'sh8000_0000;
                else                                  r2_cam[r] <= w_cam[r][31:0];
            end
        end
    end

    always_comb begin
        w_pl3       = r2_pl;
        w_pl3.zinv  = (r2_cam[2] == '0);
        w_pl3.neg_u = r2_cam[0][31] ^ r2_cam[2][31];
        w_pl3.neg_v = r2_cam[1][31] ^ r2_cam[2][31];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_pl       <= w_pl3;
            r3_dvd_u    <= f_abs(r2_cam[0]) * i_cfg.focal_x;
            r3_dvd_v    <= f_abs(r2_cam[1]) * i_cfg.focal_y;
            r3_mz       <= f_abs(r2_cam[2]);
        end
    end

    fpr_div u_div_u (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_dvd (r3_dvd_u),
        .i_dvs (r3_mz),
        .o_quo (w_qu)
    );

    fpr_div u_div_v (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_dvd (r3_dvd_v),
        .i_dvs (r3_mz),
        .o_quo (w_qv)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dl_pl[0] <= r3_pl;
            for (int i = 1; i < LAT; i++) r_dl_pl[i] <= r_dl_pl[i-1];
            r4_pl    <= r_dl_pl[LAT-1];
            r4_u     <= f_pix(w_qu, r_dl_pl[LAT-1].neg_u, i_cfg.center_x);
            r4_v_pix <= f_pix(w_qv, r_dl_pl[LAT-1].neg_v, i_cfg.center_y);
        end
    end

    // box loads take effect in order with points at the test stage
    always_ff @(posedge i_clk) begin
        if (i_en && r4_v && r4_pl.item.opcode == fpr_pkg::OP_BOX
            && {1'b0, r4_pl.item.slot} < 5'(NB)) begin
            r_box[r4_pl.item.slot[IW-1:0]].x <= r4_pl.item.value_a;
            r_box[r4_pl.item.slot[IW-1:0]].y <= r4_pl.item.value_b;
            r_box[r4_pl.item.slot[IW-1:0]].w <= r4_pl.item.value_c;
            r_box[r4_pl.item.slot[IW-1:0]].h <= r4_pl.item.value_d;
        end
    end

    logic [15:0]        w_mask;
    logic signed [49:0] w_u, w_v, w_x0, w_x1, w_y0, w_y1;
    always_comb begin
        w_mask = '0;
        w_u = 50'(r4_u);
        w_v = 50'(r4_v_pix);
        for (int i = 0; i < NB; i++) begin
            w_x0 = 50'(r_box[i].x);
            w_x1 = 50'(r_box[i].x) + 50'(r_box[i].w);
            w_y0 = 50'(r_box[i].y);
            w_y1 = 50'(r_box[i].y) + $signed({34'd0, r_box[i].h});
            if (5'(i) < i_cfg.active_boxes && w_u >= w_x0 && w_u <= w_x1
                && w_v >= w_y0 && w_v <= w_y1) begin
                w_mask[i] = 1'b1;
            end
        end
        if (r4_pl.behind || r4_pl.zinv) w_mask = '0;
    end

    assign o_valid             = r4_v && r4_pl.item.opcode == fpr_pkg::OP_POINT;
    assign o_res.inside_mask   = w_mask;
    assign o_res.out_x         = r4_pl.item.value_a;
    assign o_res.out_y         = r4_pl.item.value_b;
    assign o_res.out_z         = r4_pl.item.value_c;
    assign o_res.out_intensity = r4_pl.item.point_intensity;
    assign o_res.behind_sensor = r4_pl.behind;
    assign o_res.depth_invalid = r4_pl.zinv && !r4_pl.behind;

endmodule
`default_nettype wire

/* sv/frustum_point_rect_classifier.sv */
// Lidar point to image box classifier.
// Input queue side: drive i_item and raise push; a beat is taken on a clock
// edge with push high and full low. Opcode OP_XFORM loads a transform word,
// OP_BOX loads a box, OP_POINT classifies a point; only points give a result.
// Result queue side: while empty is low the oldest result is on o_item; pop
// takes it. Focal lengths, principal point and the active box count are written
// through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only while
// the block is idle, and the block itself does not enforce it.
// Throughput: one beat per cycle while full is low. A point is projected through
// two 64-stage restoring dividers (one quotient bit per stage).
// Loads ride the same pipeline, so box writes stay in order with points.
// When the four-entry output queue is full and a point reaches the end of the
// pipeline, the whole pipeline holds and full rises until pop frees a slot.
// Reset (synchronous, active low) clears transform words, valid bits and queue
// state and sets the config registers to defaults; boxes hold garbage until written.
`default_nettype none
module frustum_point_rect_classifier #(
    parameter int unsigned MAX_BOXES = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire fpr_pkg::t_in  i_item,
    output logic               empty,
    input  wire logic          pop,
    output fpr_pkg::t_out      o_item,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [31:0]   i_cfg_data
);

    fpr_pkg::t_cfg r_cfg;
    fpr_pkg::t_out w_res;
    logic          w_res_v, w_en, w_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x      <= 32'h0001_0000;
            r_cfg.focal_y      <= 32'h0001_0000;
            r_cfg.center_x     <= '0;
            r_cfg.center_y     <= '0;
            r_cfg.active_boxes <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fpr_pkg::REG_FOCAL_X:  r_cfg.focal_x      <= i_cfg_data;
                fpr_pkg::REG_FOCAL_Y:  r_cfg.focal_y      <= i_cfg_data;
                fpr_pkg::REG_CENTER_X: r_cfg.center_x     <= i_cfg_data;
                fpr_pkg::REG_CENTER_Y: r_cfg.center_y     <= i_cfg_data;
                fpr_pkg::REG_ACTIVE:   r_cfg.active_boxes <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign w_en = !(w_res_v && w_q_full);
    assign full = !w_en;

    fpr_front #(
        .MAX_BOXES (MAX_BOXES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (push && w_en),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .o_valid (w_res_v),
        .o_res   (w_res)
    );

    fpr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_v),
        .i_data  (w_res),
        .o_full  (w_q_full),
        .o_empty (empty),
        .i_rd    (pop),
        .o_data  (o_item)
    );

endmodule
`default_nettype wire
